>>> rtl/core/lfsa_pkg.sv
// Shared types and constants for the lowest free slot allocator.
`timescale 1ns / 1ps

package lfsa_pkg;

   localparam int STALL_W         = 11;
   localparam int CLIENT_W        = 10;
   localparam int SLOT_W          = 11;
   localparam int WORD_BITS       = 64;
   localparam int BIT_W           = 6;
   localparam int DEF_MAX_SLOTS   = 1024;
   localparam int DEF_MAX_CLIENTS = 1024;
   localparam logic [STALL_W-1:0] STALL_RESET = 11'd1024;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_FREE  = 2'd1,
      STATUS_NOT_HELD = 2'd2
   } status_type;

   typedef struct packed {
      logic                is_start;
      logic [CLIENT_W-1:0] client_id;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot_number;
      logic [SLOT_W-1:0] busy_count;
      logic [SLOT_W-1:0] peak_count;
      status_type        status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_SEARCH,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic fetch;
      logic search;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic out_free;
   } dp_status_type;

endpackage

>>> rtl/core/lfsa_ctrl.sv
// Sequencing state machine for the lowest free slot allocator.
`timescale 1ns / 1ps

module lfsa_ctrl import lfsa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type stat,
   output cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_SEARCH;
         end
         ST_SEARCH: begin
            cmd.search = 1'b1;
            state_in   = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

>>> rtl/core/lfsa_datapath.sv
// Bitmaps, assignment table, counters and result register of the allocator.
`timescale 1ns / 1ps

module lfsa_datapath import lfsa_pkg::*; #(
   parameter int MAX_SLOTS   = DEF_MAX_SLOTS,
   parameter int MAX_CLIENTS = DEF_MAX_CLIENTS
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output dp_status_type      stat,
   input  req_type            req_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [STALL_W-1:0] csr_data,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output rsp_type            rsp_data
);

   localparam int WORD_COUNT = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int WD_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int CL_W       = $clog2(MAX_CLIENTS);
   localparam int SN_W       = $clog2(MAX_SLOTS + 1);
   localparam int CLEAR_LEN  = (MAX_CLIENTS > WORD_COUNT) ? MAX_CLIENTS : WORD_COUNT;
   localparam int CLR_W      = $clog2(CLEAR_LEN);

   // client_id reduced modulo MAX_CLIENTS by restoring subtraction
   function automatic logic [CLIENT_W-1:0] client_wrap(input logic [CLIENT_W-1:0] id);
      logic [31:0] v;
      logic [31:0] m;
      v = 32'(id);
      for (int k = CLIENT_W - 1; k >= 0; k--) begin
         m = 32'(MAX_CLIENTS) << k;
         if (v >= m) begin
            v = v - m;
         end
      end
      return CLIENT_W'(v);
   endfunction

   logic [WORD_BITS-1:0] free_mem [WORD_COUNT];
   logic [SN_W-1:0]      held_mem [MAX_CLIENTS];

   logic [STALL_W-1:0]    stall_ff;
   logic [WORD_COUNT-1:0] summary_ff;
   logic [WORD_COUNT-1:0] summary_in;
   logic [SN_W-1:0]       busy_ff;
   logic [SN_W-1:0]       busy_in;
   logic [SN_W-1:0]       peak_ff;
   logic [SN_W-1:0]       peak_in;
   logic [CLR_W-1:0]      clr_cnt_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;
   rsp_type               rsp_data_in;

   logic                  start_ff;
   logic [CL_W-1:0]       client_ff;
   logic [SN_W-1:0]       held_rd_ff;
   logic [WD_W-1:0]       wsel_ff;
   logic                  any_ff;
   logic [WORD_BITS-1:0]  word_ff;
   logic [WD_W-1:0]       word_addr_ff;
   logic [BIT_W-1:0]      end_bit_ff;
   logic                  h_ok_ff;
   logic [BIT_W-1:0]      bit_ff;
   logic                  ok_ff;

   logic [CL_W-1:0]       client_idx;
   logic [WD_W-1:0]       sum_sel;
   logic [BIT_W-1:0]      low_bit;
   logic [31:0]           hm1;
   logic [WD_W-1:0]       fetch_addr;
   logic                  h_ok;
   logic [31:0]           full_bit;
   logic [31:0]           limit;
   logic                  found;
   logic [WORD_BITS-1:0]  bit_mask;
   logic [WORD_BITS-1:0]  new_word;
   logic [SN_W-1:0]       grant;
   logic [SN_W-1:0]       slot;
   logic [WORD_BITS-1:0]  init_word;

   logic                  fw_en;
   logic [WD_W-1:0]       fw_addr;
   logic [WORD_BITS-1:0]  fw_data;
   logic                  hw_en;
   logic [CL_W-1:0]       hw_addr;
   logic [SN_W-1:0]       hw_data;

   assign client_idx = CL_W'(client_wrap(req_data.client_id));

   always_comb begin
      sum_sel = '0;
      for (int i = WORD_COUNT - 1; i >= 0; i--) begin
         if (summary_ff[i]) begin
            sum_sel = WD_W'(i);
         end
      end
   end

   always_comb begin
      low_bit = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (word_ff[i]) begin
            low_bit = BIT_W'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         init_word[i] = ((32'(clr_cnt_ff) << BIT_W) + 32'(i)) < 32'(MAX_SLOTS);
      end
   end

   assign hm1        = 32'(held_rd_ff) - 32'd1;
   assign fetch_addr = start_ff ? wsel_ff : hm1[BIT_W +: WD_W];
   assign h_ok       = (held_rd_ff != '0) && (held_rd_ff <= SN_W'(MAX_SLOTS));

   assign full_bit = 32'({word_addr_ff, low_bit});
   assign limit    = (32'(stall_ff) < 32'(MAX_SLOTS)) ? 32'(stall_ff) : 32'(MAX_SLOTS);
   assign found    = any_ff && (word_ff != '0) && (full_bit < limit);

   assign bit_mask = WORD_BITS'(1) << bit_ff;
   assign new_word = start_ff ? (word_ff & ~bit_mask) : (word_ff | bit_mask);
   assign grant    = SN_W'({word_addr_ff, bit_ff}) + SN_W'(1);
   assign slot     = start_ff ? grant : held_rd_ff;

   always_comb begin
      busy_in    = busy_ff;
      summary_in = summary_ff;
      if (ok_ff) begin
         if (start_ff) begin
            busy_in = busy_ff + SN_W'(1);
            if (new_word == '0) begin
               summary_in[word_addr_ff] = 1'b0;
            end
         end else begin
            if (busy_ff != '0) begin
               busy_in = busy_ff - SN_W'(1);
            end
            summary_in[word_addr_ff] = 1'b1;
         end
      end
      peak_in = (busy_in > peak_ff) ? busy_in : peak_ff;
   end

   always_comb begin
      rsp_data_in.slot_number = ok_ff ? SLOT_W'(slot) : '0;
      rsp_data_in.busy_count  = SLOT_W'(busy_in);
      rsp_data_in.peak_count  = SLOT_W'(peak_in);
      if (ok_ff) begin
         rsp_data_in.status = STATUS_OK;
      end else if (start_ff) begin
         rsp_data_in.status = STATUS_NO_FREE;
      end else begin
         rsp_data_in.status = STATUS_NOT_HELD;
      end
   end

   // one write port per table, shared by the clearing pass and commit
   always_comb begin
      if (cmd.clear) begin
         fw_en   = 32'(clr_cnt_ff) < 32'(WORD_COUNT);
         fw_addr = WD_W'(clr_cnt_ff);
         fw_data = init_word;
         hw_en   = 32'(clr_cnt_ff) < 32'(MAX_CLIENTS);
         hw_addr = CL_W'(clr_cnt_ff);
         hw_data = '0;
      end else begin
         fw_en   = cmd.commit && ok_ff;
         fw_addr = word_addr_ff;
         fw_data = new_word;
         hw_en   = cmd.commit && ok_ff;
         hw_addr = client_ff;
         hw_data = start_ff ? grant : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (fw_en) begin
         free_mem[fw_addr] <= fw_data;
      end
      if (cmd.fetch) begin
         word_ff <= free_mem[fetch_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (hw_en) begin
         held_mem[hw_addr] <= hw_data;
      end
      if (cmd.accept) begin
         held_rd_ff <= held_mem[client_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         start_ff  <= req_data.is_start;
         client_ff <= client_idx;
         wsel_ff   <= sum_sel;
         any_ff    <= summary_ff != '0;
      end
      if (cmd.fetch) begin
         word_addr_ff <= fetch_addr;
         end_bit_ff   <= hm1[BIT_W-1:0];
         h_ok_ff      <= h_ok;
      end
      if (cmd.search) begin
         bit_ff <= start_ff ? low_bit : end_bit_ff;
         ok_ff  <= start_ff ? found : h_ok_ff;
      end
      if (cmd.commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stall_ff     <= STALL_RESET;
         summary_ff   <= '1;
         busy_ff      <= '0;
         peak_ff      <= '0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            stall_ff <= csr_data;
         end
         if (cmd.clear) begin
            clr_cnt_ff <= clr_cnt_ff + CLR_W'(1);
         end
         if (cmd.commit) begin
            summary_ff   <= summary_in;
            busy_ff      <= busy_in;
            peak_ff      <= peak_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.clear_done = clr_cnt_ff == CLR_W'(CLEAR_LEN - 1);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;
   assign csr_ready       = !reset;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

endmodule

>>> rtl/core/lowest_free_slot_allocator_top.sv
// Top level of the lowest free slot allocator.
`timescale 1ns / 1ps

// Grants each start transaction the lowest-numbered free resource in
// 1..min(stall_count, MAX_SLOTS) and frees it on the client's end
// transaction, tracking current and peak busy counts. One transaction is
// in flight at a time: accept, table/bitmap fetch, lowest-bit search and
// commit run in turn, and the next transaction is taken only after commit;
// a result waiting in the output register does not block the next accept,
// only the next commit. The bitmap words and the client table sit in
// single-port synchronous memories, which set the fetch/commit split.
// After reset a clearing pass over every bitmap word and client table
// entry runs before the first transaction is accepted; csr writes are
// taken at any time outside reset.
module lowest_free_slot_allocator_top import lfsa_pkg::*; #(
   parameter int MAX_SLOTS   = DEF_MAX_SLOTS,
   parameter int MAX_CLIENTS = DEF_MAX_CLIENTS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [STALL_W-1:0] csr_data
);

   cmd_type       cmd;
   dp_status_type stat;

   lfsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lfsa_datapath #(
      .MAX_SLOTS   (MAX_SLOTS),
      .MAX_CLIENTS (MAX_CLIENTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("transaction accepted while another is in flight");

   a_error_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |-> rsp_data.slot_number == '0)
      else $error("error result carries a slot number");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear, cmd.accept, cmd.fetch, cmd.search, cmd.commit}))
      else $error("more than one datapath command in a cycle");

   a_commit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && rsp_valid |-> rsp_ready)
      else $error("commit would overwrite an untaken result");
`endif

endmodule
